### rtl/lrg_pkg.sv
// Shared types and constants of the line raster generator.
// Used by the channel interfaces and by every RTL module; depends on nothing.
package lrg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int COORD_W = COORD_BITS;
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 16;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x_in;
        logic signed [COORD_W-1:0]  end_y_in;
        logic        [COLOR_W-1:0]  pen_color;
    } t_line_cmd;

    typedef struct packed {
        logic                       write_enable;
        logic        [ADDR_W-1:0]   pixel_address;
        logic        [COLOR_W-1:0]  pixel_color;
        logic                       last;
    } t_pixel;

    typedef struct packed {
        logic                       active;
        logic signed [COORD_W-1:0]  cur_x;
        logic signed [COORD_W-1:0]  cur_y;
        logic signed [COORD_W-1:0]  goal_x;
        logic signed [COORD_W-1:0]  goal_y;
        logic        [DELTA_W-1:0]  delta_x;
        logic        [DELTA_W-1:0]  delta_y;
        logic                       step_x_neg;
        logic                       step_y_neg;
        logic signed [ERR_W-1:0]    error_term;
        logic        [COLOR_W-1:0]  line_color;
    } t_line_state;

endpackage

### rtl/lrg_if.sv
// Valid/ready channel interfaces for line commands and pixel results.
// Depends on lrg_pkg for the payload types.
interface lrg_cmd_if import lrg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_line_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lrg_pix_if import lrg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lrg_setup.sv
// Line setup: endpoint deltas, step directions and initial error term.
// Depends on lrg_pkg.
module lrg_setup import lrg_pkg::*; (
    input  t_line_cmd   i_cmd,
    output t_line_state o_line
);

    logic signed [DELTA_W-1:0] x1;
    logic signed [DELTA_W-1:0] y1;
    logic signed [DELTA_W-1:0] x2;
    logic signed [DELTA_W-1:0] y2;
    logic                      x_lt;
    logic                      y_lt;
    logic        [DELTA_W-1:0] dx;
    logic        [DELTA_W-1:0] dy;
    logic signed [ERR_W-1:0]   half_dx;
    logic signed [ERR_W-1:0]   half_dy;

    assign x1 = DELTA_W'(i_cmd.start_x);
    assign y1 = DELTA_W'(i_cmd.start_y);
    assign x2 = DELTA_W'(i_cmd.end_x_in);
    assign y2 = DELTA_W'(i_cmd.end_y_in);

    assign x_lt = x1 < x2;
    assign y_lt = y1 < y2;

    assign dx = x_lt ? DELTA_W'(x2 - x1) : DELTA_W'(x1 - x2);
    assign dy = y_lt ? DELTA_W'(y2 - y1) : DELTA_W'(y1 - y2);

    // deltas are non-negative, so a shift halves toward zero
    assign half_dx = $signed(ERR_W'(dx >> 1));
    assign half_dy = $signed(ERR_W'(dy >> 1));

    always_comb begin
        o_line.active     = 1'b1;
        o_line.cur_x      = i_cmd.start_x;
        o_line.cur_y      = i_cmd.start_y;
        o_line.goal_x     = i_cmd.end_x_in;
        o_line.goal_y     = i_cmd.end_y_in;
        o_line.delta_x    = dx;
        o_line.delta_y    = dy;
        o_line.step_x_neg = !x_lt;
        o_line.step_y_neg = !y_lt;
        o_line.error_term = (dx > dy) ? half_dx : -half_dy;
        o_line.line_color = i_cmd.pen_color;
    end

endmodule

### rtl/lrg_step.sv
// Pixel step: clip test and address of the current pixel, then one
// Bresenham advance. Depends on lrg_pkg.
module lrg_step import lrg_pkg::*; (
    input  t_line_state i_line,
    output t_pixel      o_pix,
    output t_line_state o_next
);

    logic                    on_screen;
    logic                    fin;
    logic [31:0]             row_base;
    logic [31:0]             addr_sum;
    logic signed [ERR_W-1:0] dx_s;
    logic signed [ERR_W-1:0] dy_s;
    logic signed [ERR_W-1:0] e2;
    logic                    move_x;
    logic                    move_y;

    assign on_screen = (int'(i_line.cur_x) >= 0) && (int'(i_line.cur_x) < SCREEN_WIDTH) &&
                       (int'(i_line.cur_y) >= 0) && (int'(i_line.cur_y) < SCREEN_HEIGHT);
    assign fin = (i_line.cur_x == i_line.goal_x) && (i_line.cur_y == i_line.goal_y);

    // coordinates are non-negative whenever the address is used
    assign row_base = 32'(unsigned'(i_line.cur_y)) * 32'(SCREEN_WIDTH);
    assign addr_sum = row_base + 32'(unsigned'(i_line.cur_x));

    assign dx_s   = $signed(ERR_W'(i_line.delta_x));
    assign dy_s   = $signed(ERR_W'(i_line.delta_y));
    assign e2     = i_line.error_term;
    assign move_x = e2 > -dx_s;
    assign move_y = e2 < dy_s;

    always_comb begin
        o_pix.write_enable  = on_screen;
        o_pix.pixel_address = on_screen ? addr_sum[ADDR_W-1:0] : '0;
        o_pix.pixel_color   = i_line.line_color;
        o_pix.last          = fin;
    end

    always_comb begin
        o_next = i_line;
        if (fin) begin
            o_next.active = 1'b0;
        end else begin
            o_next.error_term = e2 - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
            if (move_x) begin
                o_next.cur_x = i_line.step_x_neg ? i_line.cur_x - COORD_W'(1)
                                                 : i_line.cur_x + COORD_W'(1);
            end
            if (move_y) begin
                o_next.cur_y = i_line.step_y_neg ? i_line.cur_y - COORD_W'(1)
                                                 : i_line.cur_y + COORD_W'(1);
            end
        end
    end

endmodule

### rtl/line_raster_generator_core.sv
// Line raster generator top level: command register, line state, pixel register.
// An accepted step command is held in the command register; its pixel is then registered in the pixel register.
// Throughput: one command per cycle while no pixel waits; a pixel-emitting step stalls while the pixel output is held.
// A start command yields no pixel; a step with no active line is dropped.
// Synchronous active-low reset clears the line state and both valid flags.
module line_raster_generator_core import lrg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lrg_cmd_if.sink  i_cmd,
    lrg_pix_if.source o_pix
);

    logic        r_cmd_vld;
    logic        n_cmd_vld;
    t_line_cmd   r_cmd;
    t_line_state r_line;
    t_line_state n_line;
    logic        r_out_vld;
    logic        n_out_vld;
    t_pixel      r_out;

    t_line_state setup_line;
    t_line_state step_line;
    t_pixel      step_pix;

    logic        emit;
    logic        out_free;
    logic        go;

    lrg_setup u_setup (
        .i_cmd  (r_cmd),
        .o_line (setup_line)
    );

    lrg_step u_step (
        .i_line (r_line),
        .o_pix  (step_pix),
        .o_next (step_line)
    );

    assign emit     = (r_cmd.action == ACT_STEP) && r_line.active;
    assign out_free = !r_out_vld || o_pix.ready;
    assign go       = r_cmd_vld && (!emit || out_free);

    assign i_cmd.ready   = !r_cmd_vld || go;
    assign o_pix.valid   = r_out_vld;
    assign o_pix.payload = r_out;

    always_comb begin
        n_line = r_line;
        if (go) begin
            if (r_cmd.action == ACT_START) begin
                n_line = setup_line;
            end else if (emit) begin
                n_line = step_line;
            end
        end
    end

    assign n_cmd_vld = i_cmd.ready ? i_cmd.valid : r_cmd_vld;
    assign n_out_vld = (go && emit) ? 1'b1 : (o_pix.ready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_line    <= '0;
        end else begin
            r_cmd_vld <= n_cmd_vld;
            r_out_vld <= n_out_vld;
            r_line    <= n_line;
        end
    end

    // payload registers: load on transfer only
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd <= i_cmd.payload;
        end
        if (go && emit) begin
            r_out <= step_pix;
        end
    end

endmodule
